>>> src/tel_pkg.sv
// shared types and constants of the timestamped event ring logger
`default_nettype none

package tel_pkg;

    localparam int LOG_ENTRIES_DEF = 64;

    localparam int OP_W      = 2;
    localparam int COUNT_W   = 16;
    localparam int BCD_W     = 20;
    localparam int WORD_W    = 32;
    localparam int ROLL_W    = 8;
    localparam int WARN_W    = 7;
    localparam int ICON_W    = 2;

    // remainder unit: 18-bit dividend, divisor up to 13 bits
    // quotient by reciprocal multiply, then one multiply and subtract
    localparam int REM_W     = 18;
    localparam int DIV_W     = 13;
    localparam int RECIP_W   = 29;
    localparam int RECIP_SH  = 30;
    localparam int QUO_W     = 16;
    localparam int YEAR_MOD  = 200;

    localparam int STEP_W    = 3;
    localparam int RD_WORDS  = 4;

    localparam logic [OP_W-1:0] OP_TALLY     = 2'd0;
    localparam logic [OP_W-1:0] OP_CNT_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_LOG = 2'd2;
    localparam logic [OP_W-1:0] OP_READ      = 2'd3;

    localparam logic [ICON_W-1:0] ICON_OFF   = 2'd0;
    localparam logic [ICON_W-1:0] ICON_BLINK = 2'd1;
    localparam logic [ICON_W-1:0] ICON_ON    = 2'd2;

    localparam logic [1:0] MUL_HOUR = 2'd0;
    localparam logic [1:0] MUL_MIN  = 2'd1;
    localparam logic [1:0] MUL_SEC  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       quo_step;
        logic       fold_step;
        logic       stamp;
        logic       mul;
        logic [1:0] mul_sel;
        logic       wr_log;
        logic       rd_issue;
        logic       rd_first;
        logic       rd_capture;
        logic [1:0] rd_slot;
        logic       header;
        logic       cnt_zero;
        logic       done;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            burst_zero;
        logic            clr_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/tel_ctrl.sv
// sequencer of the event logger: steps the datapath through each opcode
`default_nettype none

module tel_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output tel_pkg::dp_cmd_t      cmd,
    input  wire tel_pkg::dp_status_t status
);
    import tel_pkg::*;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_ZERO     = 4'd3;
    localparam logic [3:0] S_CLEAR    = 4'd4;
    localparam logic [3:0] S_HEADER   = 4'd5;
    localparam logic [3:0] S_QUO      = 4'd6;
    localparam logic [3:0] S_STAMP    = 4'd7;
    localparam logic [3:0] S_MUL1     = 4'd8;
    localparam logic [3:0] S_MUL2     = 4'd9;
    localparam logic [3:0] S_MUL3     = 4'd10;
    localparam logic [3:0] S_WRITE    = 4'd11;
    localparam logic [3:0] S_READ     = 4'd12;
    localparam logic [3:0] S_FINISH   = 4'd13;
    localparam logic [3:0] S_FOLD     = 4'd14;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                step_next = '0;
                unique case (status.op)
                    OP_TALLY:     state_next = S_QUO;
                    OP_CNT_RESET: state_next = S_ZERO;
                    OP_CLEAR_LOG: state_next = S_CLEAR;
                    default:      state_next = status.burst_zero ? S_HEADER : S_QUO;
                endcase
            end
            S_ZERO:
            begin
                cmd.cnt_zero = 1'b1;
                state_next   = S_FINISH;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = S_FINISH;
            end
            S_HEADER:
            begin
                cmd.header = 1'b1;
                state_next = S_FINISH;
            end
            S_QUO:
            begin
                cmd.quo_step = 1'b1;
                state_next   = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold_step = 1'b1;
                state_next    = (status.op == OP_TALLY) ? S_STAMP : S_READ;
            end
            S_STAMP:
            begin
                cmd.stamp  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_HOUR;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_MIN;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_SEC;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_log = 1'b1;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                // each word is captured in the cycle after its read is issued
                cmd.rd_issue   = (step_reg < STEP_W'(RD_WORDS));
                cmd.rd_first   = (step_reg == '0);
                cmd.rd_capture = (step_reg != '0);
                cmd.rd_slot    = 2'(step_reg - 1'b1);
                step_next      = step_reg + 1'b1;
                if (step_reg == STEP_W'(RD_WORDS))
                begin
                    step_next  = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/tel_dp.sv
// datapath of the event logger: timestamp math, ring memory, counters and result words
`default_nettype none

module tel_dp #(
    parameter int LOG_ENTRIES = tel_pkg::LOG_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tel_pkg::dp_cmd_t             cmd,
    output tel_pkg::dp_status_t               status,
    input  wire logic [tel_pkg::OP_W-1:0]     opcode,
    input  wire logic [11:0]                  year,
    input  wire logic [3:0]                   month,
    input  wire logic [4:0]                   day,
    input  wire logic [4:0]                   hour,
    input  wire logic [5:0]                   minute,
    input  wire logic [5:0]                   second,
    input  wire logic [15:0]                  burst,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tel_pkg::WARN_W-1:0]   cfg_wr_data,
    output logic                              done,
    output logic [tel_pkg::BCD_W-1:0]         count_bcd,
    output logic [tel_pkg::WORD_W-1:0]        word_a,
    output logic [tel_pkg::WORD_W-1:0]        word_b,
    output logic [tel_pkg::WORD_W-1:0]        word_c,
    output logic [tel_pkg::WORD_W-1:0]        word_d,
    output logic [tel_pkg::ICON_W-1:0]        icon_state
);
    import tel_pkg::*;

    localparam int AW = $clog2(LOG_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(LOG_ENTRIES - 1);
    localparam int PROD_W = REM_W + RECIP_W;
    localparam int FOLD_W = QUO_W + DIV_W;

    // reciprocals rounded up: exact quotient for any dividend below 2^REM_W
    localparam logic [RECIP_W-1:0] IDX_RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) / 64'(LOG_ENTRIES)) + 64'd1);
    localparam logic [RECIP_W-1:0] YEAR_RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) / 64'(YEAR_MOD)) + 64'd1);

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             c;
        r = v;
        c = 1'b1;
        for (int k = 0; k < BCD_W / 4; k++)
        begin
            if (c)
            begin
                if (r[4*k +: 4] == 4'd9)
                    r[4*k +: 4] = 4'd0;
                else
                begin
                    r[4*k +: 4] = r[4*k +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // captured item
    logic [OP_W-1:0]   op_reg;
    logic [11:0]       year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        minute_reg;
    logic [5:0]        second_reg;
    logic              burst_zero_reg;

    // state
    logic [COUNT_W-1:0] tally_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [AW-1:0]      wp_reg;
    logic [ROLL_W-1:0]  roll_reg;
    logic [ICON_W-1:0]  icon_reg;
    logic [WARN_W-1:0]  warn_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               done_reg;

    // working registers
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [WORD_W-1:0]  mem_q_reg;
    logic [WORD_W-1:0]  word_reg [RD_WORDS];

    logic [WORD_W-1:0]  log_mem [LOG_ENTRIES];

    logic [RECIP_W-1:0] recip;
    logic [DIV_W-1:0]   divisor;
    logic [PROD_W-1:0]  quo_prod;
    logic [FOLD_W-1:0]  fold_prod;
    logic [7:0]         y;
    logic [16:0]        y365;
    logic [6:0]         yq;
    logic               leap;
    logic [WORD_W-1:0]  days;
    logic [5:0]         mul_k;
    logic [5:0]         mul_add;
    logic [WORD_W-1:0]  prod;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wp_next;
    logic [ROLL_W-1:0]  roll_next;
    logic [15:0]        burst_m1;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [WORD_W-1:0]  mem_wd;

    assign status.op         = op_reg;
    assign status.burst_zero = burst_zero_reg;
    assign status.clr_last   = (clr_addr_reg == LAST_ADDR);

    // year mod 200 for a tally, first burst index mod ring size for a read
    assign recip     = (op_reg == OP_TALLY) ? YEAR_RECIP : IDX_RECIP;
    assign divisor   = (op_reg == OP_TALLY) ? DIV_W'(YEAR_MOD) : DIV_W'(LOG_ENTRIES);
    assign quo_prod  = PROD_W'(rem_reg) * PROD_W'(recip);
    assign fold_prod = FOLD_W'(quo_reg) * FOLD_W'(divisor);

    // day number since the epoch
    assign y    = rem_reg[7:0];
    assign y365 = 17'(y) * 17'd365;
    assign yq   = 7'((9'(y) + 9'd3) >> 2);
    assign leap = (month_reg >= 4'd3) && (month_reg <= 4'd12) && (year_reg[1:0] == 2'd0);
    assign days = 32'(y365) + 32'(yq) + 32'(days_before(month_reg)) + 32'(leap)
                + 32'(day_reg) - 32'd1;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_HOUR:
            begin
                mul_k   = 6'd24;
                mul_add = 6'(hour_reg);
            end
            MUL_MIN:
            begin
                mul_k   = 6'd60;
                mul_add = minute_reg;
            end
            default:
            begin
                mul_k   = 6'd60;
                mul_add = second_reg;
            end
        endcase
    end

    assign prod = acc_reg * 32'(mul_k);

    assign rd_addr   = cmd.rd_first ? rem_reg[AW-1:0] : rd_idx_reg;
    assign wp_next   = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign roll_next = (wp_reg == LAST_ADDR) ? roll_reg + 1'b1 : roll_reg;
    assign burst_m1  = burst - 16'd1;

    assign mem_we = cmd.clr_step || cmd.wr_log;
    assign mem_wa = cmd.clr_step ? clr_addr_reg : wp_reg;
    assign mem_wd = cmd.clr_step ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            log_mem[mem_wa] <= mem_wd;
        if (cmd.rd_issue)
            mem_q_reg <= log_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= opcode;
            year_reg       <= year;
            month_reg      <= month;
            day_reg        <= day;
            hour_reg       <= hour;
            minute_reg     <= minute;
            second_reg     <= second;
            burst_zero_reg <= (burst == 16'd0);
            for (int k = 0; k < RD_WORDS; k++)
                word_reg[k] <= '0;
            if (opcode == OP_TALLY)
                rem_reg <= REM_W'(year);
            else
                rem_reg <= {burst_m1, 2'b00};
        end
        else
        begin
            if (cmd.quo_step)
                quo_reg <= QUO_W'(quo_prod >> RECIP_SH);
            if (cmd.fold_step)
                rem_reg <= rem_reg - REM_W'(fold_prod);
            if (cmd.stamp)
                acc_reg <= days;
            if (cmd.mul)
                acc_reg <= prod + 32'(mul_add);
            if (cmd.wr_log)
                word_reg[0] <= acc_reg;
            if (cmd.header)
            begin
                word_reg[0] <= WORD_W'(LOG_ENTRIES);
                word_reg[1] <= WORD_W'(wp_reg);
                word_reg[2] <= WORD_W'(roll_reg);
            end
            if (cmd.rd_issue)
                rd_idx_reg <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + 1'b1;
            if (cmd.rd_capture)
                word_reg[cmd.rd_slot] <= mem_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg    <= '0;
            bcd_reg      <= '0;
            wp_reg       <= '0;
            roll_reg     <= '0;
            icon_reg     <= ICON_OFF;
            warn_reg     <= WARN_W'(48);
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cfg_wr_en)
                warn_reg <= cfg_wr_data;
            if (cmd.clr_step)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
                wp_reg       <= '0;
                roll_reg     <= '0;
                icon_reg     <= ICON_OFF;
            end
            if (cmd.cnt_zero)
            begin
                tally_reg <= '0;
                bcd_reg   <= '0;
            end
            if (cmd.wr_log)
            begin
                tally_reg <= tally_reg + 1'b1;
                // 16-bit count wraps to zero after 65535
                bcd_reg   <= (tally_reg == '1) ? '0 : bcd_inc(bcd_reg);
                wp_reg    <= wp_next;
                roll_reg  <= roll_next;
                if (roll_next != '0)
                    icon_reg <= ICON_ON;
                else if (16'(wp_next) > 16'(warn_reg))
                    icon_reg <= ICON_BLINK;
            end
        end
    end

    assign done       = done_reg;
    assign count_bcd  = bcd_reg;
    assign word_a     = word_reg[0];
    assign word_b     = word_reg[1];
    assign word_c     = word_reg[2];
    assign word_d     = word_reg[3];
    assign icon_state = icon_reg;

endmodule

`default_nettype wire

>>> src/timestamped_event_ring_logger_core.sv
// top level of the timestamped event ring logger
//
// command port: an item (opcode and its fields) is taken at a clock edge with start high
// and busy low. each item gives one result word on count_bcd, word_a..word_d and
// icon_state, valid for the single cycle in which done is high; the receiver cannot
// stall and must take it then.
// tally and read burst share a remainder unit (reciprocal multiply, then multiply and
// subtract). a tally runs the remainder, day math, three multiply steps and the log write
// before the edge that takes its result; a read burst runs the remainder, then four
// single-port memory reads. clear log sweeps the ring one entry a cycle.
// one item is worked at a time; busy stays high until its result is issued.
// after reset the ring is cleared by the same sweep, with busy high;
// cfg_wr_en / cfg_wr_data write warn_level (reset 48) at any edge and are taken at once,
// but should only be written while idle.
`default_nettype none

module timestamped_event_ring_logger_core #(
    parameter int LOG_ENTRIES = tel_pkg::LOG_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tel_pkg::OP_W-1:0]     opcode,
    input  wire logic [11:0]                  year,
    input  wire logic [3:0]                   month,
    input  wire logic [4:0]                   day,
    input  wire logic [4:0]                   hour,
    input  wire logic [5:0]                   minute,
    input  wire logic [5:0]                   second,
    input  wire logic [15:0]                  burst,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tel_pkg::WARN_W-1:0]   cfg_wr_data,
    output logic                              done,
    output logic [tel_pkg::BCD_W-1:0]         count_bcd,
    output logic [tel_pkg::WORD_W-1:0]        word_a,
    output logic [tel_pkg::WORD_W-1:0]        word_b,
    output logic [tel_pkg::WORD_W-1:0]        word_c,
    output logic [tel_pkg::WORD_W-1:0]        word_d,
    output logic [tel_pkg::ICON_W-1:0]        icon_state
);
    import tel_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tel_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    tel_dp #(
        .LOG_ENTRIES (LOG_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (opcode),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .burst       (burst),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .count_bcd   (count_bcd),
        .word_a      (word_a),
        .word_b      (word_b),
        .word_c      (word_c),
        .word_d      (word_d),
        .icon_state  (icon_state)
    );

endmodule

`default_nettype wire

>>> test/timestamped_event_ring_logger_core_tb.sv
// testbench for the timestamped event ring logger core: self-checking random and directed run
`timescale 1ns / 100ps

module timestamped_event_ring_logger_core_tb;
    import tel_pkg::*;

    localparam int RING_DEPTH   = LOG_ENTRIES_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_WORDS  = 260;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [11:0]     year;
        logic [3:0]      month;
        logic [4:0]      day;
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [5:0]      second;
        logic [15:0]     burst;
    } event_word_t;

    typedef struct packed {
        logic [BCD_W-1:0]  count_bcd;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [ICON_W-1:0] icon;
    } logger_result_t;

    class event_log_scoreboard;
        logic [WARN_W-1:0]  warn_level;
        logic [COUNT_W-1:0] tally;
        logic [WORD_W-1:0]  ring [RING_DEPTH];
        int unsigned        wr_pos;
        logic [ROLL_W-1:0]  rolls;
        logic [ICON_W-1:0]  icon;
        logger_result_t     expected_results [$];
        int                 errors;

        function new();
            warn_level = 7'd48;
            tally = '0;
            foreach (ring[i]) ring[i] = '0;
            wr_pos = 0;
            rolls = '0;
            icon = ICON_OFF;
            errors = 0;
        endfunction

        function logic [WORD_W-1:0] epoch_seconds(event_word_t w);
            logic [31:0] y;
            logic [31:0] t;
            int m;
            y = 32'(w.year) % 200;
            t = y * 365 + (y + 3) / 4;
            // out-of-range months add no month days
            if (w.month >= 1 && w.month <= 12) begin
                for (m = 1; m < w.month; m++)
                    t += (m == 2) ? 28 : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
                if (w.month >= 3 && w.year % 4 == 0)
                    t += 1;
            end
            t = t + 32'(w.day) - 32'd1;
            t = t * 24 + 32'(w.hour);
            t = t * 60 + 32'(w.minute);
            t = t * 60 + 32'(w.second);
            return t;
        endfunction

        function logic [BCD_W-1:0] bcd_of(logic [COUNT_W-1:0] v);
            logic [BCD_W-1:0] r;
            int unsigned n;
            int k;
            n = 32'(v);
            r = '0;
            for (k = 0; k < 5; k++)
            begin
                r[4*k +: 4] = 4'(n % 10);
                n = n / 10;
            end
            return r;
        endfunction

        function void note_word(event_word_t w);
            logger_result_t r;
            logic [WORD_W-1:0] words [RD_WORDS];
            int unsigned first;
            int i;
            r = '0;
            foreach (words[j]) words[j] = '0;
            case (w.op)
                OP_TALLY:
                begin
                    words[0] = epoch_seconds(w);
                    tally = tally + 1'b1;
                    ring[wr_pos] = words[0];
                    wr_pos++;
                    if (wr_pos == RING_DEPTH)
                    begin
                        wr_pos = 0;
                        rolls = rolls + 1'b1;
                    end
                    // icon keeps its state when neither rule fires
                    if (rolls != 0)
                        icon = ICON_ON;
                    else if (wr_pos > warn_level)
                        icon = ICON_BLINK;
                end
                OP_CNT_RESET:
                    tally = '0;
                OP_CLEAR_LOG:
                begin
                    foreach (ring[j]) ring[j] = '0;
                    wr_pos = 0;
                    rolls = '0;
                    icon = ICON_OFF;
                end
                OP_READ:
                begin
                    if (w.burst == 0)
                    begin
                        words[0] = RING_DEPTH;
                        words[1] = wr_pos;
                        words[2] = WORD_W'(rolls);
                    end
                    else
                    begin
                        first = ((32'(w.burst) - 1) * 4) % RING_DEPTH;
                        for (i = 0; i < RD_WORDS; i++)
                            words[i] = ring[(first + i) % RING_DEPTH];
                    end
                end
            endcase
            r.count_bcd = bcd_of(tally);
            r.word_a = words[0];
            r.word_b = words[1];
            r.word_c = words[2];
            r.word_d = words[3];
            r.icon = icon;
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logger_result_t got);
            logger_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("count_bcd", WORD_W'(want.count_bcd), WORD_W'(got.count_bcd));
            check_field("word_a", want.word_a, got.word_a);
            check_field("word_b", want.word_b, got.word_b);
            check_field("word_c", want.word_c, got.word_c);
            check_field("word_d", want.word_d, got.word_d);
            check_field("icon_state", WORD_W'(want.icon), WORD_W'(got.icon));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OP_W-1:0]     opcode = '0;
    logic [11:0]         year = '0;
    logic [3:0]          month = '0;
    logic [4:0]          day = '0;
    logic [4:0]          hour = '0;
    logic [5:0]          minute = '0;
    logic [5:0]          second = '0;
    logic [15:0]         burst = '0;
    logic                cfg_wr_en = 1'b0;
    logic [WARN_W-1:0]   cfg_wr_data = '0;
    logic                busy;
    logic                done;
    logic [BCD_W-1:0]    count_bcd;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
    logic [WORD_W-1:0]   word_c;
    logic [WORD_W-1:0]   word_d;
    logic [ICON_W-1:0]   icon_state;
    int unsigned         quiet_cycles = 0;

    event_log_scoreboard sb = new();

    timestamped_event_ring_logger_core #(
        .LOG_ENTRIES(RING_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .year(year),
        .month(month),
        .day(day),
        .hour(hour),
        .minute(minute),
        .second(second),
        .burst(burst),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done(done),
        .count_bcd(count_bcd),
        .word_a(word_a),
        .word_b(word_b),
        .word_c(word_c),
        .word_d(word_d),
        .icon_state(icon_state)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_word(logger_result_t'{count_bcd, word_a, word_b, word_c, word_d, icon_state});
    end

    // stall guard: any accepted word or issued result resets the count
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic event_word_t calendar_tally();
        event_word_t w;
        w.op = OP_TALLY;
        w.year = 12'($urandom_range(2000, 2199));
        w.month = 4'($urandom_range(1, 12));
        w.day = 5'($urandom_range(1, 31));
        w.hour = 5'($urandom_range(0, 23));
        w.minute = 6'($urandom_range(0, 59));
        w.second = 6'($urandom_range(0, 59));
        w.burst = 16'($urandom);
        return w;
    endfunction

    function automatic event_word_t tally_at(int y, int mo, int d, int h, int mi, int s);
        event_word_t w;
        w = '0;
        w.op = OP_TALLY;
        w.year = 12'(y);
        w.month = 4'(mo);
        w.day = 5'(d);
        w.hour = 5'(h);
        w.minute = 6'(mi);
        w.second = 6'(s);
        return w;
    endfunction

    function automatic event_word_t command(logic [OP_W-1:0] op, int b);
        event_word_t w;
        w = '0;
        w.op = op;
        w.burst = 16'(b);
        return w;
    endfunction

    function automatic event_word_t random_word();
        event_word_t w;
        int pick;
        w = calendar_tally();
        pick = $urandom_range(0, 99);
        if (pick < 62)
            w.op = OP_TALLY;
        else if (pick < 88)
            w.op = OP_READ;
        else if (pick < 98)
            w.op = OP_CNT_RESET;
        else
            w.op = OP_CLEAR_LOG;
        // occasional raw field bits, possibly out of calendar range
        if ($urandom_range(0, 15) == 0)
        begin
            w.year = 12'($urandom);
            w.month = 4'($urandom);
            w.day = 5'($urandom);
            w.hour = 5'($urandom);
            w.minute = 6'($urandom);
            w.second = 6'($urandom);
        end
        w.burst = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        return w;
    endfunction

    task automatic send_word(event_word_t w, int gap, bit settle);
        if (gap > 0 || settle)
            start <= 1'b0;
        // settle lets the gap count from the end of the previous word
        if (settle)
        begin
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
        opcode <= w.op;
        year <= w.year;
        month <= w.month;
        day <= w.day;
        hour <= w.hour;
        minute <= w.minute;
        second <= w.second;
        burst <= w.burst;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_warn(logic [WARN_W-1:0] v);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.warn_level = v;
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int k;
        bit burst_mode;
        logic [WARN_W-1:0] warn_plan [6];
        event_word_t directed_words [$];

        burst_mode = 1'b0;
        warn_plan = '{7'd0, 7'd64, 7'd63, 7'd5, 7'd31, 7'd0};
        warn_plan[5] = 7'($urandom_range(0, 64));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        directed_words.push_back(command(OP_READ, 0));
        directed_words.push_back(tally_at(2000, 1, 1, 0, 0, 0));
        directed_words.push_back(tally_at(2199, 12, 31, 23, 59, 59));
        directed_words.push_back(tally_at(2000, 2, 29, 12, 30, 45));
        directed_words.push_back(tally_at(2004, 3, 1, 0, 0, 0));
        directed_words.push_back(tally_at(2100, 3, 1, 6, 7, 8));
        directed_words.push_back(tally_at(2001, 0, 10, 1, 2, 3));
        directed_words.push_back(tally_at(2003, 13, 5, 4, 5, 6));
        directed_words.push_back(tally_at(2150, 15, 31, 22, 0, 1));
        directed_words.push_back(tally_at(2020, 6, 0, 0, 0, 0));
        directed_words.push_back(tally_at(4095, 15, 31, 31, 63, 63));
        directed_words.push_back(tally_at(0, 7, 4, 23, 59, 59));
        directed_words.push_back(command(OP_READ, 1));
        directed_words.push_back(command(OP_READ, 2));
        directed_words.push_back(command(OP_READ, 65535));
        directed_words.push_back(command(OP_READ, 17));
        directed_words.push_back(command(OP_CNT_RESET, 0));
        directed_words.push_back(command(OP_READ, 0));
        directed_words.push_back(command(OP_CLEAR_LOG, 0));
        directed_words.push_back(command(OP_READ, 1));
        directed_words.push_back(command(OP_READ, 0));
        directed_words.push_back(tally_at(2024, 2, 29, 23, 59, 59));
        foreach (directed_words[i])
            send_word(directed_words[i], $urandom_range(0, 6), 1'($urandom_range(0, 1)));

        for (phase = 0; phase < 6; phase++)
        begin
            write_warn(warn_plan[phase]);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                    burst_mode = !burst_mode;
                if (burst_mode)
                    send_word(random_word(), 0, 1'b0);
                else
                    send_word(random_word(), $urandom_range(0, 6), $urandom_range(0, 3) == 0);
            end
            // back-to-back tallies over three ring passes so the roll counter moves
            if (phase == 2)
            begin
                send_word(command(OP_CLEAR_LOG, 0), 0, 1'b0);
                for (k = 0; k < 3 * RING_DEPTH; k++)
                    send_word(calendar_tally(), 0, 1'b0);
                send_word(command(OP_READ, 0), 0, 1'b0);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
